// ===== hdl/ipid3_pkg.sv =====
// Shared types and constants of the three-axis incremental PID block.
// Request and response payload structs, register map and control-register bundle.
// Used by ipid3_csr and incremental_pid_three_axis; depends on nothing else.
package ipid3_pkg;

   localparam int unsigned AXIS_COUNT_DEF = 3;
   localparam int unsigned FRAC_BITS_DEF  = 8;

   // Axes that own gain and calibration registers.
   localparam int unsigned REG_AXES = 3;

   localparam int unsigned ANGLE_W  = 16;
   localparam int unsigned ERR_W    = ANGLE_W + 1;
   localparam int unsigned GAIN_W   = 16;
   localparam int unsigned GAINS_W  = 3 * GAIN_W;
   localparam int unsigned LIMIT_W  = 23;
   localparam int unsigned DRIVE_W  = 24;
   localparam int unsigned AXIS_W   = 2;
   localparam int unsigned CSR_IDX_W = 3;

   // Bit positions of the three gains inside one packed gain register.
   localparam int unsigned KP_LSB = 32;
   localparam int unsigned KI_LSB = 16;
   localparam int unsigned KD_LSB = 0;

   // Widths of the error differences, the products and the accumulator.
   localparam int unsigned D1_W   = ERR_W + 1;
   localparam int unsigned D2_W   = ERR_W + 2;
   localparam int unsigned PROD_W = GAIN_W + D2_W + 1;
   localparam int unsigned SUM_W  = PROD_W + 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAINS_X      = 3'd0,
      CSR_GAINS_Y      = 3'd1,
      CSR_GAINS_Z      = 3'd2,
      CSR_OUTPUT_LIMIT = 3'd3,
      CSR_CALIB_X      = 3'd4,
      CSR_CALIB_Y      = 3'd5,
      CSR_CALIB_Z      = 3'd6
   } csr_index_type;

   typedef enum logic {
      OP_STEP  = 1'b0,
      OP_CLEAR = 1'b1
   } op_type;

   typedef struct packed {
      logic                        operation;
      logic [AXIS_W-1:0]           axis;
      logic signed [ANGLE_W-1:0]   angle;
   } req_type;

   typedef struct packed {
      logic [AXIS_W-1:0]           axis_out;
      logic signed [DRIVE_W-1:0]   drive;
      logic                        saturated;
   } rsp_type;

   typedef struct packed {
      logic [REG_AXES-1:0][GAINS_W-1:0] gains;
      logic [LIMIT_W-1:0]               limit;
      logic [REG_AXES-1:0][ANGLE_W-1:0] calib;
   } csr_type;

endpackage

// ===== hdl/incremental_pid_three_axis.sv =====
// Three-axis incremental (velocity-form) PID controller, top level; needs ipid3_pkg, ipid3_csr.
// A request accepted into the input register reaches rsp_data through the product register
// and then the response register, with exactly one response each.
// One request per cycle unless a held response stalls; the three 16-bit gain multipliers
// and the drive adder are each used once per request. Synchronous active-high reset empties
// the pipeline, zeroes the error and drive history of every axis and resets the registers.
module incremental_pid_three_axis #(
   parameter int unsigned AXIS_COUNT = ipid3_pkg::AXIS_COUNT_DEF,
   parameter int unsigned FRAC_BITS  = ipid3_pkg::FRAC_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  ipid3_pkg::req_type                 req_data,
   // Response channel.
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output ipid3_pkg::rsp_type                 rsp_data,
   // Register write port.
   input  logic                               csr_we,
   input  logic [ipid3_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ipid3_pkg::GAINS_W-1:0]      csr_wdata
);

   // Width of an index into the per-axis history.
   localparam int unsigned IDX_W = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

   localparam int unsigned ERR_W   = ipid3_pkg::ERR_W;
   localparam int unsigned D1_W    = ipid3_pkg::D1_W;
   localparam int unsigned D2_W    = ipid3_pkg::D2_W;
   localparam int unsigned PROD_W  = ipid3_pkg::PROD_W;
   localparam int unsigned SUM_W   = ipid3_pkg::SUM_W;
   localparam int unsigned DRIVE_W = ipid3_pkg::DRIVE_W;
   localparam int unsigned GAIN_W  = ipid3_pkg::GAIN_W;

   ipid3_pkg::csr_type regs;

   ipid3_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .regs      (regs)
   );

   // ------------------------------------------------------------------
   // Pipeline flow control. Each stage advances when it is empty or when
   // the stage after it is moving on, so a held response only stops the
   // requests that actually have nowhere to go.
   // ------------------------------------------------------------------
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic out_free, s2_free, s1_free;
   logic s1_move, s2_move, req_take;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign s2_move  = s2_valid_ff && out_free;
   assign s1_move  = s1_valid_ff && s2_free;
   assign req_take = req_valid && s1_free;

   assign req_stall = !s1_free;

   assign s1_valid_in  = s1_free  ? req_valid   : s1_valid_ff;
   assign s2_valid_in  = s2_free  ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = out_free ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: input register. From it the error and its differences are
   // formed and multiplied by the axis gains. The error history is read
   // and written here, so a following request of the same axis always
   // sees the values left by this one.
   // ------------------------------------------------------------------
   ipid3_pkg::req_type s1_req_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff <= req_data;
      end
   end

   logic signed [ERR_W-1:0] last_error_ff [AXIS_COUNT];
   logic signed [ERR_W-1:0] error_before_last_ff [AXIS_COUNT];

   logic                    s1_in_range;
   logic                    s1_has_regs;
   logic [IDX_W-1:0]        s1_idx;
   logic [ipid3_pkg::GAINS_W-1:0] s1_gains;
   logic signed [ipid3_pkg::ANGLE_W-1:0] s1_calib;
   logic signed [ERR_W-1:0] s1_err, s1_e1, s1_e2;
   logic signed [D1_W-1:0]  s1_d1;
   logic signed [D2_W-1:0]  s1_d2;
   logic signed [GAIN_W:0]  s1_kp, s1_ki, s1_kd;
   logic signed [PROD_W-1:0] s1_prod_p, s1_prod_i, s1_prod_d;

   always_comb begin
      s1_in_range = 32'(s1_req_ff.axis) < AXIS_COUNT;
      s1_has_regs = 32'(s1_req_ff.axis) < ipid3_pkg::REG_AXES;
      s1_idx      = s1_in_range ? IDX_W'(s1_req_ff.axis) : '0;
      // Axes without their own registers run with zero gains and calibration.
      s1_gains    = s1_has_regs ? regs.gains[s1_req_ff.axis] : '0;
      s1_calib    = s1_has_regs ? $signed(regs.calib[s1_req_ff.axis]) : '0;

      s1_err = ERR_W'(s1_req_ff.angle) - ERR_W'(s1_calib);
      s1_e1  = last_error_ff[s1_idx];
      s1_e2  = error_before_last_ff[s1_idx];

      s1_d1 = D1_W'(s1_err) - D1_W'(s1_e1);
      s1_d2 = D2_W'(s1_err) - (D2_W'(s1_e1) <<< 1) + D2_W'(s1_e2);

      s1_kp = $signed({1'b0, s1_gains[ipid3_pkg::KP_LSB +: GAIN_W]});
      s1_ki = $signed({1'b0, s1_gains[ipid3_pkg::KI_LSB +: GAIN_W]});
      s1_kd = $signed({1'b0, s1_gains[ipid3_pkg::KD_LSB +: GAIN_W]});

      s1_prod_p = PROD_W'(s1_kp) * PROD_W'(s1_d1);
      s1_prod_i = PROD_W'(s1_ki) * PROD_W'(s1_err);
      s1_prod_d = PROD_W'(s1_kd) * PROD_W'(s1_d2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int unsigned i = 0; i < AXIS_COUNT; i++) begin
            last_error_ff[i]        <= '0;
            error_before_last_ff[i] <= '0;
         end
      end else if (s1_move && s1_in_range) begin
         if (s1_req_ff.operation == ipid3_pkg::OP_CLEAR) begin
            last_error_ff[s1_idx]        <= '0;
            error_before_last_ff[s1_idx] <= '0;
         end else begin
            error_before_last_ff[s1_idx] <= s1_e1;
            last_error_ff[s1_idx]        <= s1_err;
         end
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: product register. The products are summed, scaled down by
   // the fraction bits (arithmetic shift, so it rounds toward minus
   // infinity), added to the axis's previous drive and clamped.
   // ------------------------------------------------------------------
   logic                     s2_op_ff;
   logic [ipid3_pkg::AXIS_W-1:0] s2_axis_ff;
   logic                     s2_in_range_ff;
   logic [IDX_W-1:0]         s2_idx_ff;
   logic signed [PROD_W-1:0] s2_prod_p_ff, s2_prod_i_ff, s2_prod_d_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_op_ff       <= s1_req_ff.operation;
         s2_axis_ff     <= s1_req_ff.axis;
         s2_in_range_ff <= s1_in_range;
         s2_idx_ff      <= s1_idx;
         s2_prod_p_ff   <= s1_prod_p;
         s2_prod_i_ff   <= s1_prod_i;
         s2_prod_d_ff   <= s1_prod_d;
      end
   end

   logic signed [DRIVE_W-1:0] last_drive_ff [AXIS_COUNT];

   logic signed [SUM_W-1:0]   s2_sum, s2_scaled, s2_unclamped, s2_lim;
   logic signed [DRIVE_W-1:0] s2_drive;
   logic                      s2_sat;
   logic                      s2_step;
   ipid3_pkg::rsp_type        s2_rsp;

   always_comb begin
      s2_step = s2_in_range_ff && (s2_op_ff == ipid3_pkg::OP_STEP);
      s2_sum  = SUM_W'(s2_prod_p_ff) + SUM_W'(s2_prod_i_ff) + SUM_W'(s2_prod_d_ff);
      s2_scaled    = s2_sum >>> FRAC_BITS;
      s2_unclamped = s2_scaled + SUM_W'(last_drive_ff[s2_idx_ff]);
      s2_lim       = SUM_W'(regs.limit);

      priority if (s2_unclamped > s2_lim) begin
         s2_drive = DRIVE_W'(s2_lim);
         s2_sat   = 1'b1;
      end else if (s2_unclamped < -s2_lim) begin
         s2_drive = DRIVE_W'(-s2_lim);
         s2_sat   = 1'b1;
      end else begin
         s2_drive = DRIVE_W'(s2_unclamped);
         s2_sat   = 1'b0;
      end

      // Clears and axes beyond the configured count report a zero drive.
      s2_rsp.axis_out  = s2_axis_ff;
      s2_rsp.drive     = s2_step ? s2_drive : '0;
      s2_rsp.saturated = s2_step && s2_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int unsigned i = 0; i < AXIS_COUNT; i++) begin
            last_drive_ff[i] <= '0;
         end
      end else if (s2_move && s2_in_range_ff) begin
         last_drive_ff[s2_idx_ff] <= s2_rsp.drive;
      end
   end

   // ------------------------------------------------------------------
   // Response register.
   // ------------------------------------------------------------------
   ipid3_pkg::rsp_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_data_ff <= s2_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   property p_drive_within_limit;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff |-> (rsp_data_ff.drive <= $signed(DRIVE_W'(regs.limit)))
                       && (rsp_data_ff.drive >= -$signed(DRIVE_W'(regs.limit)));
   endproperty
   a_drive_within_limit: assert property (p_drive_within_limit)
      else $error("drive exceeds the output limit");

   property p_saturated_at_limit;
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && rsp_data_ff.saturated)
            |-> (rsp_data_ff.drive == $signed(DRIVE_W'(regs.limit)))
             || (rsp_data_ff.drive == -$signed(DRIVE_W'(regs.limit)));
   endproperty
   a_saturated_at_limit: assert property (p_saturated_at_limit)
      else $error("saturated response does not sit on the limit");

   property p_out_of_range_zero;
      @(posedge clock) disable iff (reset)
         (rsp_valid_ff && (32'(rsp_data_ff.axis_out) >= AXIS_COUNT))
            |-> (rsp_data_ff.drive == '0) && !rsp_data_ff.saturated;
   endproperty
   a_out_of_range_zero: assert property (p_out_of_range_zero)
      else $error("response for an absent axis carries a drive");

   property p_stall_only_when_full;
      @(posedge clock) disable iff (reset)
         req_stall |-> s1_valid_ff && s2_valid_ff && rsp_valid_ff && rsp_stall;
   endproperty
   a_stall_only_when_full: assert property (p_stall_only_when_full)
      else $error("request stalled while the pipeline has room");

endmodule

// ===== hdl/ipid3_csr.sv =====
// Control registers of the three-axis incremental PID block: gains, limit, calibration.
// Depends on ipid3_pkg for the register map and the csr_type bundle.
module ipid3_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ipid3_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ipid3_pkg::GAINS_W-1:0]        csr_wdata,
   output ipid3_pkg::csr_type                   regs
);

   ipid3_pkg::csr_type regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.gains <= '0;
         regs_ff.limit <= ipid3_pkg::LIMIT_RESET;
         regs_ff.calib <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ipid3_pkg::CSR_GAINS_X:      regs_ff.gains[0] <= csr_wdata;
            ipid3_pkg::CSR_GAINS_Y:      regs_ff.gains[1] <= csr_wdata;
            ipid3_pkg::CSR_GAINS_Z:      regs_ff.gains[2] <= csr_wdata;
            ipid3_pkg::CSR_OUTPUT_LIMIT:
               regs_ff.limit <= csr_wdata[ipid3_pkg::LIMIT_W-1:0];
            ipid3_pkg::CSR_CALIB_X:
               regs_ff.calib[0] <= csr_wdata[ipid3_pkg::ANGLE_W-1:0];
            ipid3_pkg::CSR_CALIB_Y:
               regs_ff.calib[1] <= csr_wdata[ipid3_pkg::ANGLE_W-1:0];
            ipid3_pkg::CSR_CALIB_Z:
               regs_ff.calib[2] <= csr_wdata[ipid3_pkg::ANGLE_W-1:0];
            default: begin
               // Writes to unmapped indexes are dropped.
            end
         endcase
      end
   end

   assign regs = regs_ff;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the three-axis incremental PID block.
// Drives requests and register writes and checks every response against an in-bench predictor.
// Depends on ipid3_pkg and on the RTL top level incremental_pid_three_axis.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // The run is cut off at this many clock cycles.
   localparam int unsigned CYCLE_LIMIT = 400000;
   // A register index with no register behind it; writes to it must be ignored.
   localparam logic [ipid3_pkg::CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;
   localparam logic signed [ipid3_pkg::ANGLE_W-1:0] ANGLE_MAX = 16'sh7FFF;
   localparam logic signed [ipid3_pkg::ANGLE_W-1:0] ANGLE_MIN = -16'sh8000;
   localparam logic [ipid3_pkg::LIMIT_W-1:0] LIMIT_MAX = {ipid3_pkg::LIMIT_W{1'b1}};
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned ITEMS_PER_PHASE = 250;

   // Register indexes of the per-axis registers, so loops can address them by axis.
   localparam ipid3_pkg::csr_index_type GAIN_REG [ipid3_pkg::REG_AXES] =
      '{ipid3_pkg::CSR_GAINS_X, ipid3_pkg::CSR_GAINS_Y, ipid3_pkg::CSR_GAINS_Z};
   localparam ipid3_pkg::csr_index_type CALIB_REG [ipid3_pkg::REG_AXES] =
      '{ipid3_pkg::CSR_CALIB_X, ipid3_pkg::CSR_CALIB_Y, ipid3_pkg::CSR_CALIB_Z};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   ipid3_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   ipid3_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [ipid3_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ipid3_pkg::GAINS_W-1:0] csr_wdata = '0;

   incremental_pid_three_axis dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 12 ns clock period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Requests waiting to be driven, and the responses the predictor expects, oldest first.
   ipid3_pkg::req_type req_backlog[$];
   ipid3_pkg::rsp_type drive_expect_q[$];

   // Predictor copy of the register file.
   logic [ipid3_pkg::GAINS_W-1:0] gain_reg [ipid3_pkg::REG_AXES];
   logic [ipid3_pkg::LIMIT_W-1:0] limit_reg;
   logic signed [ipid3_pkg::ANGLE_W-1:0] calib_reg [ipid3_pkg::REG_AXES];

   // Predictor copy of the per-axis history: the last two errors and the last drive.
   longint err_last [ipid3_pkg::AXIS_COUNT_DEF];
   longint err_prev [ipid3_pkg::AXIS_COUNT_DEF];
   longint drive_last [ipid3_pkg::AXIS_COUNT_DEF];

   // Bookkeeping for the summary and the verdict.
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned step_count = 0;
   int unsigned clear_count = 0;
   int unsigned stray_axis_count = 0;
   int unsigned clamp_count = 0;
   int unsigned response_count = 0;
   int unsigned setting_count = 0;

   // Random walk of the angle on each axis, so most steps look like a real sensor trace.
   logic signed [ipid3_pkg::ANGLE_W-1:0] angle_track [ipid3_pkg::REG_AXES];

   // Computes the response to one accepted request and advances the predictor state.
   // The error differences and the three products are exact in 64 bits; an arithmetic
   // right shift gives the floor division by 2^FRAC_BITS.
   function automatic ipid3_pkg::rsp_type pid_expect(ipid3_pkg::req_type r);
      ipid3_pkg::rsp_type o;
      longint e;
      longint kp;
      longint ki;
      longint kd;
      longint acc;
      longint u;
      longint lim;
      int unsigned a;
      o = '0;
      o.axis_out = r.axis;
      a = r.axis;
      if (a >= ipid3_pkg::AXIS_COUNT_DEF) begin
         // An axis beyond the configured count leaves every state alone.
         stray_axis_count++;
      end else if (r.operation == ipid3_pkg::OP_CLEAR) begin
         clear_count++;
         err_last[a] = 0;
         err_prev[a] = 0;
         drive_last[a] = 0;
      end else begin
         step_count++;
         e = longint'($signed(r.angle)) - longint'(calib_reg[a]);
         kp = longint'(gain_reg[a][ipid3_pkg::KP_LSB +: ipid3_pkg::GAIN_W]);
         ki = longint'(gain_reg[a][ipid3_pkg::KI_LSB +: ipid3_pkg::GAIN_W]);
         kd = longint'(gain_reg[a][ipid3_pkg::KD_LSB +: ipid3_pkg::GAIN_W]);
         acc = kp * (e - err_last[a]) + ki * e + kd * (e - 2 * err_last[a] + err_prev[a]);
         u = drive_last[a] + (acc >>> ipid3_pkg::FRAC_BITS_DEF);
         lim = longint'(limit_reg);
         if (u > lim) begin
            u = lim;
            o.saturated = 1'b1;
         end else if (u < -lim) begin
            u = -lim;
            o.saturated = 1'b1;
         end
         if (o.saturated)
            clamp_count++;
         err_prev[a] = err_last[a];
         err_last[a] = e;
         drive_last[a] = u;
         o.drive = ipid3_pkg::DRIVE_W'(u);
      end
      return o;
   endfunction

   // Draws the idle cycles before the next request or after the next response.
   // In a quiet stretch there is no idling at all.
   function automatic int unsigned draw_wait(bit quiet);
      return quiet ? 0 : $urandom_range(0, 5);
   endfunction

   // Request driver. The next request goes out only when the current one has been
   // accepted or none is on the bus, so a stalled request holds still and valid is
   // assigned once per edge.
   int unsigned req_gap_left = 0;
   bit req_quiet = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_valid && !req_stall)
            drive_expect_q.push_back(pid_expect(req_data));
         if (!req_valid || !req_stall) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_data <= req_backlog.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 63) == 0)
                  req_quiet = !req_quiet;
               req_gap_left = draw_wait(req_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic log_mismatch(string what, longint want, longint got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   // Response monitor. It compares each accepted response with the oldest expectation
   // and then stalls for a drawn number of cycles; stalls also land while nothing is
   // valid, so they cover every stage of the pipeline.
   int unsigned rsp_hold_left = 0;
   bit rsp_quiet = 1'b0;

   always @(posedge clock) begin
      ipid3_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            response_count++;
            if (drive_expect_q.size() == 0) begin
               log_mismatch("unexpected response, axis", -1, rsp_data.axis_out);
            end else begin
               want = drive_expect_q.pop_front();
               if (rsp_data.axis_out !== want.axis_out)
                  log_mismatch("axis_out", want.axis_out, rsp_data.axis_out);
               if (rsp_data.drive !== want.drive)
                  log_mismatch("drive", longint'(want.drive), longint'(rsp_data.drive));
               if (rsp_data.saturated !== want.saturated)
                  log_mismatch("saturated", want.saturated, rsp_data.saturated);
            end
            if ($urandom_range(0, 63) == 0)
               rsp_quiet = !rsp_quiet;
            rsp_hold_left = draw_wait(rsp_quiet);
         end else if (rsp_hold_left > 0) begin
            rsp_hold_left--;
         end
         rsp_stall <= (rsp_hold_left > 0);
      end
   end

   always @(posedge clock)
      cycle_count++;

   // Watchdog: a hung handshake ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT)
         @(posedge clock);
      $display("Timeout after %0d cycles with %0d responses outstanding.",
               cycle_count, drive_expect_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Writes one register at the coming edge and mirrors it into the predictor.
   // Called at a rising edge; back-to-back calls keep the write enable high.
   task automatic put_reg(logic [ipid3_pkg::CSR_IDX_W-1:0] idx,
                          logic [ipid3_pkg::GAINS_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      unique case (idx)
         ipid3_pkg::CSR_GAINS_X, ipid3_pkg::CSR_GAINS_Y, ipid3_pkg::CSR_GAINS_Z:
            gain_reg[2'(idx - ipid3_pkg::CSR_GAINS_X)] = value;
         ipid3_pkg::CSR_OUTPUT_LIMIT:
            limit_reg = value[ipid3_pkg::LIMIT_W-1:0];
         ipid3_pkg::CSR_CALIB_X, ipid3_pkg::CSR_CALIB_Y, ipid3_pkg::CSR_CALIB_Z:
            calib_reg[2'(idx - ipid3_pkg::CSR_CALIB_X)] = value[ipid3_pkg::ANGLE_W-1:0];
         default: ;
      endcase
   endtask

   // Waits until every request has been accepted and every response has come back.
   // Each request gives exactly one response, so the block is then idle.
   task automatic wait_idle();
      while (req_backlog.size() > 0 || req_valid || drive_expect_q.size() > 0)
         @(posedge clock);
   endtask

   task automatic queue_req(logic op, logic [ipid3_pkg::AXIS_W-1:0] ax,
                            logic signed [ipid3_pkg::ANGLE_W-1:0] ang);
      ipid3_pkg::req_type r;
      r.operation = op;
      r.axis = ax;
      r.angle = ang;
      req_backlog.push_back(r);
   endtask

   // Gain register content for one axis: small gains keep the loop mostly out of
   // saturation, random and full-scale gains exercise the full product width.
   function automatic logic [ipid3_pkg::GAINS_W-1:0] make_gains(int unsigned mode);
      unique case (mode)
         0, 1, 2: return {16'($urandom_range(0, 'h300)), 16'($urandom_range(0, 'h100)),
                          16'($urandom_range(0, 'h300))};
         3: return {16'($urandom), 16'($urandom), 16'($urandom)};
         4: return '0;
         default: return {ipid3_pkg::GAINS_W{1'b1}};
      endcase
   endfunction

   // One random request. Most are control steps that follow a slow random walk per
   // axis; the rest are jumps, extreme angles, clears and requests for the unused axis.
   task automatic queue_random_req();
      int unsigned roll;
      int unsigned a;
      int delta;
      roll = $urandom_range(0, 99);
      a = $urandom_range(0, ipid3_pkg::REG_AXES - 1);
      if (roll < 4) begin
         queue_req(1'($urandom), 2'd3, 16'($urandom));
      end else if (roll < 10) begin
         queue_req(ipid3_pkg::OP_CLEAR, 2'(a), 16'($urandom));
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            delta = int'($urandom_range(0, 600)) - 300;
            angle_track[a] = angle_track[a] + 16'(delta);
         end else if (roll < 85) begin
            angle_track[a] = 16'($urandom);
         end else if (roll < 90) begin
            angle_track[a] = ANGLE_MAX;
         end else if (roll < 95) begin
            angle_track[a] = ANGLE_MIN;
         end else begin
            angle_track[a] = calib_reg[a];
         end
         queue_req(ipid3_pkg::OP_STEP, 2'(a), angle_track[a]);
      end
   endtask

   initial begin
      logic [ipid3_pkg::LIMIT_W-1:0] lim;
      logic signed [ipid3_pkg::ANGLE_W-1:0] cal;
      int unsigned mode;

      // Predictor state after reset.
      for (int i = 0; i < ipid3_pkg::REG_AXES; i++) begin
         gain_reg[i] = '0;
         calib_reg[i] = '0;
         angle_track[i] = '0;
      end
      limit_reg = ipid3_pkg::LIMIT_RESET;
      for (int i = 0; i < ipid3_pkg::AXIS_COUNT_DEF; i++) begin
         err_last[i] = 0;
         err_prev[i] = 0;
         drive_last[i] = 0;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset values: all gains zero, so every step drives zero.
      @(negedge clock);
      queue_req(ipid3_pkg::OP_STEP, 2'd0, ANGLE_MAX);
      queue_req(ipid3_pkg::OP_STEP, 2'd1, ANGLE_MIN);
      queue_req(ipid3_pkg::OP_STEP, 2'd3, 16'sd100);

      // Directed setting: unit-ish gains on x, full-scale gains on y, calibrations at
      // both extremes on y and z so the error reaches its full 17-bit range.
      wait_idle();
      setting_count++;
      put_reg(ipid3_pkg::CSR_GAINS_X, {16'h0100, 16'h0080, 16'h0040});
      put_reg(ipid3_pkg::CSR_GAINS_Y, {ipid3_pkg::GAINS_W{1'b1}});
      put_reg(ipid3_pkg::CSR_GAINS_Z, {16'h0200, 16'h0000, 16'h0100});
      put_reg(ipid3_pkg::CSR_OUTPUT_LIMIT, {25'h1ABCDEF, LIMIT_MAX});
      put_reg(ipid3_pkg::CSR_CALIB_X, '0);
      put_reg(ipid3_pkg::CSR_CALIB_Y, {32'hFFFF_0000, ANGLE_MAX});
      put_reg(ipid3_pkg::CSR_CALIB_Z, {32'h0000_FFFF, ANGLE_MIN});
      put_reg(CSR_UNUSED_INDEX, {ipid3_pkg::GAINS_W{1'b1}});
      csr_we <= 1'b0;
      @(negedge clock);
      queue_req(ipid3_pkg::OP_STEP, 2'd0, 16'sd256);
      queue_req(ipid3_pkg::OP_STEP, 2'd0, 16'sd512);
      queue_req(ipid3_pkg::OP_STEP, 2'd0, ANGLE_MIN);
      queue_req(ipid3_pkg::OP_STEP, 2'd0, ANGLE_MAX);
      queue_req(ipid3_pkg::OP_CLEAR, 2'd0, ANGLE_MAX);
      queue_req(ipid3_pkg::OP_STEP, 2'd0, 16'sd256);
      // Most negative error with full gains clamps low, then the mirror case clamps high.
      queue_req(ipid3_pkg::OP_STEP, 2'd1, ANGLE_MIN);
      queue_req(ipid3_pkg::OP_STEP, 2'd1, ANGLE_MAX);
      queue_req(ipid3_pkg::OP_STEP, 2'd1, ANGLE_MAX);
      queue_req(ipid3_pkg::OP_CLEAR, 2'd1, 16'sd0);
      queue_req(ipid3_pkg::OP_STEP, 2'd2, ANGLE_MAX);
      queue_req(ipid3_pkg::OP_STEP, 2'd2, ANGLE_MIN);
      // The unused axis answers with zero and must not disturb any real axis.
      queue_req(ipid3_pkg::OP_CLEAR, 2'd3, ANGLE_MIN);
      queue_req(ipid3_pkg::OP_STEP, 2'd3, -16'sd1);
      queue_req(ipid3_pkg::OP_CLEAR, 2'd2, 16'sd0);
      queue_req(ipid3_pkg::OP_STEP, 2'd2, 16'sd0);

      // Zero limit: every step drives zero, flagged whenever the raw value was nonzero.
      wait_idle();
      setting_count++;
      put_reg(ipid3_pkg::CSR_OUTPUT_LIMIT, '0);
      csr_we <= 1'b0;
      @(negedge clock);
      queue_req(ipid3_pkg::OP_STEP, 2'd0, 16'sd1000);
      queue_req(ipid3_pkg::OP_STEP, 2'd0, 16'sd1000);
      queue_req(ipid3_pkg::OP_STEP, 2'd0, 16'sd1000);
      queue_req(ipid3_pkg::OP_CLEAR, 2'd0, 16'sd0);
      queue_req(ipid3_pkg::OP_STEP, 2'd0, 16'sd0);

      // Random phases, each under a fresh register setting. Phase 1 has a zero limit,
      // phase 2 the largest limit, phase 3 all gains at full scale, phase 5 the
      // calibrations at their extremes.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_idle();
         setting_count++;
         for (int a = 0; a < ipid3_pkg::REG_AXES; a++) begin
            if (p == 0)
               mode = 0;
            else if (p == 3)
               mode = 5;
            else
               mode = $urandom_range(0, 5);
            put_reg(GAIN_REG[a], make_gains(mode));
         end
         unique case (p)
            1: lim = '0;
            2: lim = LIMIT_MAX;
            4: lim = ipid3_pkg::LIMIT_W'($urandom_range(1, 2000));
            default: lim = ipid3_pkg::LIMIT_W'($urandom);
         endcase
         put_reg(ipid3_pkg::CSR_OUTPUT_LIMIT, {25'($urandom), lim});
         for (int a = 0; a < ipid3_pkg::REG_AXES; a++) begin
            if (p == 5)
               cal = (a % 2 == 0) ? ANGLE_MAX : ANGLE_MIN;
            else
               cal = 16'($urandom);
            put_reg(CALIB_REG[a], {32'($urandom), cal});
            angle_track[a] = cal;
         end
         put_reg(CSR_UNUSED_INDEX, {16'($urandom), 16'($urandom), 16'($urandom)});
         csr_we <= 1'b0;
         @(negedge clock);
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            queue_random_req();
      end

      // Drain, then give the pipeline a few more edges to show any stray response.
      wait_idle();
      repeat (8) @(posedge clock);

      $display("Ran %0d requests (%0d steps, %0d clears, %0d on the unused axis) under %0d %s",
               step_count + clear_count + stray_axis_count, step_count, clear_count,
               stray_axis_count, setting_count, "settings.");
      $display("Checked %0d responses, %0d of them clamped; %0d mismatches in %0d cycles.",
               response_count, clamp_count, mismatch_count, cycle_count);
      if (mismatch_count == 0 && drive_expect_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/ipid3_pkg.sv
hdl/ipid3_csr.sv
hdl/incremental_pid_three_axis.sv
verif/testbench.sv
